>>> rtl/sndm_pkg.sv
package sndm_pkg;

	localparam int unsigned DISP_W               = 16;
	localparam int unsigned DEPTH_W              = 16;
	localparam int unsigned FB_W                 = 24;
	localparam int unsigned MIN_DIST_W           = 16;
	localparam int unsigned COUNT_W              = 21;
	localparam int unsigned PIXEL_COUNT_BITS_DEF = 20;
	localparam int unsigned CFG_DATA_W           = 32;
	localparam int unsigned CFG_ADDR_W           = 3;
	localparam int unsigned QUEUE_DEPTH          = 4;

	localparam logic [MIN_DIST_W-1:0] MIN_DIST_RST = 16'd512;
	localparam logic [FB_W-1:0]       FB_RST       = 24'd21504;
	localparam logic [DEPTH_W-1:0]    DEPTH_MAX    = {DEPTH_W{1'b1}};

	typedef enum logic {
		REG_MIN_DIST   = 1'b0,
		REG_FOCAL_BASE = 1'b1
	} cfg_reg_t;

	// One classified pixel as it travels from the depth pipeline to the accumulator.
	typedef struct packed {
		logic               near;
		logic               last;
		logic [DEPTH_W-1:0] depth;
	} pix_class_t;

endpackage

>>> rtl/sndm_front.sv
module sndm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  logic signed [sndm_pkg::DISP_W-1:0]  disparity,
	input  logic                                last_pixel,
	input  logic [sndm_pkg::FB_W-1:0]           focal_baseline,
	input  logic [sndm_pkg::MIN_DIST_W-1:0]     near_limit,
	output logic                                push,
	output sndm_pkg::pix_class_t                push_data,
	input  logic                                full
);
	import sndm_pkg::*;

	localparam int unsigned STAGES = DEPTH_W;
	localparam int unsigned NUM_W  = FB_W + 4;
	localparam int unsigned DIV_W  = DISP_W - 1;
	localparam int unsigned REM_W  = DIV_W + 1;

	typedef struct packed {
		logic               valid;
		logic               last;
		logic               no_depth;
		logic               sat;
		logic [REM_W-1:0]   rem;
		logic [DEPTH_W-1:0] num_lo;
		logic [DIV_W-1:0]   divisor;
		logic [DEPTH_W-1:0] quot;
	} div_stage_t;

	div_stage_t div_s     [STAGES+1];
	div_stage_t stage_nxt [1:STAGES];
	div_stage_t pix_in;

	logic [NUM_W-1:0]   num;
	logic               adv;
	logic               wanted;
	logic [DEPTH_W-1:0] depth;
	logic               near;

	// Stage 0 registers the pixel and settles saturation up front, so the
	// remaining quotient always fits in DEPTH_W bits.
	always_comb begin
		num             = {focal_baseline, 4'b0000};
		pix_in.valid    = pixel_valid;
		pix_in.last     = last_pixel;
		pix_in.no_depth = disparity[DISP_W-1] || (disparity == '0);
		pix_in.divisor  = disparity[DIV_W-1:0];
		pix_in.sat      = {{(DIV_W+DEPTH_W-NUM_W){1'b0}}, num} >=
		                  {disparity[DIV_W-1:0], {DEPTH_W{1'b0}}};
		pix_in.rem      = REM_W'(num[NUM_W-1:DEPTH_W]);
		pix_in.num_lo   = num[DEPTH_W-1:0];
		pix_in.quot     = '0;
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_div
		logic [REM_W-1:0] trial;
		logic             ge;

		always_comb begin
			trial = {div_s[k].rem[REM_W-2:0], div_s[k].num_lo[DEPTH_W-1]};
			ge    = trial >= {1'b0, div_s[k].divisor};
			stage_nxt[k+1]        = div_s[k];
			stage_nxt[k+1].rem    = ge ? (trial - {1'b0, div_s[k].divisor}) : trial;
			stage_nxt[k+1].num_lo = {div_s[k].num_lo[DEPTH_W-2:0], 1'b0};
			stage_nxt[k+1].quot   = {div_s[k].quot[DEPTH_W-2:0], ge};
		end
	end

	always_comb begin
		if (div_s[STAGES].no_depth) begin
			depth = '0;
		end else if (div_s[STAGES].sat) begin
			depth = DEPTH_MAX;
		end else begin
			depth = div_s[STAGES].quot;
		end
		near   = (depth != '0) && (depth < near_limit);
		// Far pixels that do not end a frame leave nothing for the back end to do.
		wanted = div_s[STAGES].valid && (near || div_s[STAGES].last);
		adv    = !(wanted && full);
		push   = wanted && !full;
		push_data.near  = near;
		push_data.last  = div_s[STAGES].last;
		push_data.depth = depth;
	end

	assign pixel_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STAGES; k++) begin
				div_s[k] <= '0;
			end
		end else if (adv) begin
			div_s[0] <= pix_in;
			for (int k = 1; k <= STAGES; k++) begin
				div_s[k] <= stage_nxt[k];
			end
		end
	end

endmodule

>>> rtl/sndm_fifo.sv
module sndm_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/sndm_back.sv
module sndm_back #(
	parameter int unsigned PIXEL_COUNT_BITS = sndm_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	output logic                            pop,
	input  sndm_pkg::pix_class_t            pop_data,
	input  logic                            empty,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [sndm_pkg::DEPTH_W-1:0]    mean_depth,
	output logic [sndm_pkg::COUNT_W-1:0]    near_count,
	output logic                            mean_valid
);
	import sndm_pkg::*;

	localparam int unsigned CNT_W  = PIXEL_COUNT_BITS + 1;
	localparam int unsigned SUM_W  = PIXEL_COUNT_BITS + DEPTH_W;
	localparam int unsigned REM_W  = CNT_W + 1;
	localparam int unsigned STEP_W = $clog2(DEPTH_W);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t             state_q;
	pix_class_t         head;
	logic               inc;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_tot;
	logic [SUM_W-1:0]   sum_tot;

	logic [CNT_W-1:0]   dvs_q;
	logic [REM_W-1:0]   rem_q;
	logic [DEPTH_W-1:0] dvd_lo_q;
	logic [DEPTH_W-1:0] quot_q;
	logic [STEP_W-1:0]  step_q;
	logic [REM_W-1:0]   trial;
	logic               ge;
	logic               res_load;

	logic               result_valid_q;
	logic [DEPTH_W-1:0] mean_q;
	logic [COUNT_W-1:0] count_q;
	logic               flag_q;

	// Once the count reaches the cap its top bit is set and further near
	// pixels are ignored until the frame ends.
	always_comb begin
		head     = pop_data;
		inc      = head.near && !cnt_q[CNT_W-1];
		cnt_tot  = inc ? cnt_q + 1'b1 : cnt_q;
		sum_tot  = inc ? sum_q + SUM_W'(head.depth) : sum_q;
		pop      = !empty && (!head.last || (state_q == S_IDLE));
		trial    = {rem_q[REM_W-2:0], dvd_lo_q[DEPTH_W-1]};
		ge       = trial >= {1'b0, dvs_q};
		res_load = (state_q == S_DONE) && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				cnt_q <= cnt_tot;
				sum_q <= sum_tot;
			end
		end
	end

	// Every depth is below 2^DEPTH_W, so the mean fits in DEPTH_W quotient bits
	// and the partial remainder starts out below the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			dvs_q          <= '0;
			rem_q          <= '0;
			dvd_lo_q       <= '0;
			quot_q         <= '0;
			step_q         <= '0;
			result_valid_q <= 1'b0;
			mean_q         <= '0;
			count_q        <= '0;
			flag_q         <= 1'b0;
		end else begin
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop && head.last) begin
						dvs_q    <= cnt_tot;
						rem_q    <= REM_W'(sum_tot[SUM_W-1:DEPTH_W]);
						dvd_lo_q <= sum_tot[DEPTH_W-1:0];
						quot_q   <= '0;
						step_q   <= '0;
						state_q  <= (cnt_tot == '0) ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					rem_q    <= ge ? (trial - {1'b0, dvs_q}) : trial;
					quot_q   <= {quot_q[DEPTH_W-2:0], ge};
					dvd_lo_q <= {dvd_lo_q[DEPTH_W-2:0], 1'b0};
					step_q   <= step_q + 1'b1;
					if (step_q == STEP_W'(DEPTH_W - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						mean_q  <= quot_q;
						count_q <= COUNT_W'(dvs_q);
						flag_q  <= (dvs_q != '0);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign mean_depth   = mean_q;
	assign near_count   = count_q;
	assign mean_valid   = flag_q;

endmodule

>>> rtl/stereo_near_depth_mean.sv
// Throughput: one pixel per cycle while the queue has room. A frame end holds the mean
// divider until its result is taken; a later frame end waits in the queue meanwhile, and
// the input stalls once the queue is full. A result passes through the 17-stage depth
// divider, the queue and the bit-serial mean divider, which is skipped when no pixel was near.
// Reset clears the accumulators, the pipeline, the queue and the output register and
// loads the proximity limit with 512 and focal_baseline with 21504.
module stereo_near_depth_mean #(
	parameter int unsigned PIXEL_COUNT_BITS = sndm_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sndm_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [sndm_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [sndm_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  logic signed [sndm_pkg::DISP_W-1:0]  disparity,
	input  logic                                last_pixel,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [sndm_pkg::DEPTH_W-1:0]        mean_depth,
	output logic [sndm_pkg::COUNT_W-1:0]        near_count,
	output logic                                mean_valid
);
	import sndm_pkg::*;

	localparam int unsigned QW = $bits(pix_class_t);

	logic [MIN_DIST_W-1:0] min_dist_q;
	logic [FB_W-1:0]       focal_base_q;
	logic                  cfg_wr;
	cfg_reg_t              cfg_sel;

	logic                  q_push;
	pix_class_t            q_push_data;
	logic                  q_full;
	logic                  q_pop;
	logic [QW-1:0]         q_pop_data;
	logic                  q_empty;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q   <= MIN_DIST_RST;
			focal_base_q <= FB_RST;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_MIN_DIST:   min_dist_q   <= pwdata[MIN_DIST_W-1:0];
				REG_FOCAL_BASE: focal_base_q <= pwdata[FB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_MIN_DIST:   prdata = CFG_DATA_W'(min_dist_q);
			REG_FOCAL_BASE: prdata = CFG_DATA_W'(focal_base_q);
			default:        prdata = '0;
		endcase
	end

	sndm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_valid    (pixel_valid),
		.pixel_stall    (pixel_stall),
		.disparity      (disparity),
		.last_pixel     (last_pixel),
		.focal_baseline (focal_base_q),
		.near_limit     (min_dist_q),
		.push           (q_push),
		.push_data      (q_push_data),
		.full           (q_full)
	);

	sndm_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	sndm_back #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (q_pop),
		.pop_data     (q_pop_data),
		.empty        (q_empty),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.mean_depth   (mean_depth),
		.near_count   (near_count),
		.mean_valid   (mean_valid)
	);

endmodule

>>> dv/stereo_near_depth_mean_tb.sv
module stereo_near_depth_mean_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sndm_pkg::*;

	localparam int unsigned NEAR_CAP = 1 << PIXEL_COUNT_BITS_DEF;
	localparam int unsigned LONG_FRAME_PIXELS = 250;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [DEPTH_W-1:0] mean;
		logic [COUNT_W-1:0] count;
		logic               valid;
	} frame_stat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  pixel_valid = 1'b0;
	logic                  pixel_stall;
	logic signed [DISP_W-1:0] disparity = '0;
	logic                  last_pixel = 1'b0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [DEPTH_W-1:0]    mean_depth;
	logic [COUNT_W-1:0]    near_count;
	logic                  mean_valid;

	// Predictor state: register copies and the per-frame accumulators.
	logic [MIN_DIST_W-1:0] min_dist_q = MIN_DIST_RST;
	logic [FB_W-1:0]       focal_base_q = FB_RST;
	logic [COUNT_W-1:0]    near_total = '0;
	logic [35:0]           depth_sum = '0;
	frame_stat_t           pending_stats[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;

	stereo_near_depth_mean i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.disparity    (disparity),
		.last_pixel   (last_pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.mean_depth   (mean_depth),
		.near_count   (near_count),
		.mean_valid   (mean_valid)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [DEPTH_W-1:0] pixel_depth_q88(input logic signed [DISP_W-1:0] d);
		logic [FB_W+3:0] quot;
		if (d <= 0)
			return '0;
		quot = {focal_base_q, 4'b0000} / {{(FB_W + 4 - DISP_W){1'b0}}, d};
		if (quot > DEPTH_MAX)
			return DEPTH_MAX;
		return quot[DEPTH_W-1:0];
	endfunction

	task automatic accumulate_pixel(input logic signed [DISP_W-1:0] d, input logic last);
		logic [DEPTH_W-1:0] dep;
		logic [35:0] avg;
		frame_stat_t stat;
		dep = pixel_depth_q88(d);
		if (dep != 0 && dep < min_dist_q && near_total < NEAR_CAP) begin
			near_total = near_total + 1'b1;
			depth_sum = depth_sum + dep;
		end
		if (last) begin
			if (near_total != 0) begin
				avg = depth_sum / near_total;
				stat.mean = (avg > DEPTH_MAX) ? DEPTH_MAX : avg[DEPTH_W-1:0];
				stat.valid = 1'b1;
			end else begin
				stat.mean = '0;
				stat.valid = 1'b0;
			end
			stat.count = near_total;
			pending_stats.push_back(stat);
			near_total = '0;
			depth_sum = '0;
		end
	endtask

	task automatic send_pixel(input logic signed [DISP_W-1:0] d, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		disparity <= d;
		last_pixel <= last;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		accumulate_pixel(d, last);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (sel)
			REG_MIN_DIST:   min_dist_q = value[MIN_DIST_W-1:0];
			REG_FOCAL_BASE: focal_base_q = value[FB_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [MIN_DIST_W-1:0] md, input logic [FB_W-1:0] fb);
		write_reg(REG_MIN_DIST, CFG_DATA_W'(md));
		write_reg(REG_FOCAL_BASE, CFG_DATA_W'(fb));
	endtask

	task automatic hold_until_empty();
		pixel_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
	endtask

	// The depth divider holds pixels that produce no result, so wait out its latency too.
	task automatic finish_outstanding();
		hold_until_empty();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [DISP_W-1:0] random_disparity();
		logic [FB_W+3:0] num;
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;
		logic signed [DISP_W-1:0] d;
		pick = $urandom_range(9);
		num = {focal_base_q, 4'b0000};
		if (pick < 2 || min_dist_q == 0) begin
			d = DISP_W'($urandom);
		end else if (pick == 2) begin
			case ($urandom_range(4))
				0: d = '0;
				1: d = -16'sd1;
				2: d = 16'sh8000;
				3: d = 16'sh0001;
				default: d = 16'sh7fff;
			endcase
		end else begin
			// Aim at the band of disparities whose depth falls below the limit.
			lo = num / min_dist_q + 1;
			hi = (num > 32767) ? 32767 : num;
			if (num == 0 || lo > hi)
				d = DISP_W'($urandom_range(32767, 1));
			else
				d = DISP_W'($urandom_range(hi, lo));
		end
		return d;
	endfunction

	task automatic flag_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		frame_stat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_stats.size() == 0) begin
				flag_mismatch("unexpected result, mean_depth", 0, mean_depth);
			end else begin
				want = pending_stats.pop_front();
				if (mean_depth !== want.mean)
					flag_mismatch("mean_depth", want.mean, mean_depth);
				if (near_count !== want.count)
					flag_mismatch("near_count", want.count, near_count);
				if (mean_valid !== want.valid)
					flag_mismatch("mean_valid", want.valid, mean_valid);
			end
		end
	end

	// Reset geometry: 2.0 m limit, so disparities above 672 are near.
	task automatic test_default_geometry();
		send_pixel(16'sd0, 1'b1);
		send_pixel(16'sh8000, 1'b0);
		send_pixel(-16'sd1, 1'b0);
		send_pixel(16'sd0, 1'b0);
		send_pixel(16'sd1, 1'b0);
		send_pixel(16'sd672, 1'b0);
		send_pixel(16'sd673, 1'b0);
		send_pixel(16'sh7fff, 1'b0);
		send_pixel(16'sd1000, 1'b1);
	endtask

	task automatic test_register_extremes();
		finish_outstanding();
		set_geometry(16'd0, 24'hffffff);
		send_pixel(16'sd673, 1'b0);
		send_pixel(16'sd1, 1'b0);
		send_pixel(16'sh7fff, 1'b1);
		finish_outstanding();
		set_geometry(16'hffff, 24'd0);
		send_pixel(16'sd1, 1'b0);
		send_pixel(16'sd100, 1'b1);
		finish_outstanding();
		// Small products give depths that truncate to zero; the write mid-frame
		// must leave the accumulators alone.
		set_geometry(16'hffff, 24'd1);
		send_pixel(16'sd16, 1'b0);
		send_pixel(16'sd17, 1'b0);
		send_pixel(16'sd8, 1'b0);
		finish_outstanding();
		write_reg(REG_FOCAL_BASE, CFG_DATA_W'(2));
		send_pixel(16'sd16, 1'b1);
		finish_outstanding();
		// A depth that saturates is never below the limit.
		set_geometry(16'hffff, 24'hffffff);
		send_pixel(16'sd4096, 1'b0);
		send_pixel(16'sd4097, 1'b0);
		send_pixel(16'sh7fff, 1'b1);
	endtask

	// A long frame of near pixels whose depths sit just below saturation.
	task automatic test_long_frame();
		int unsigned i;
		finish_outstanding();
		send_idle_pct = 0;
		stall_pct = 0;
		set_geometry(16'hffff, 24'hffffff);
		for (i = 0; i < LONG_FRAME_PIXELS; i++)
			send_pixel(16'sd4097, 1'b0);
		send_pixel(16'sd4097, 1'b1);
	endtask

	task automatic test_random_frames();
		int k;
		int sent;
		int len;
		int i;
		logic [MIN_DIST_W-1:0] md;
		logic [FB_W-1:0] fb;
		for (k = 0; k < 8; k++) begin
			finish_outstanding();
			case (k / 2)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 67; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 67; end
				default: begin send_idle_pct = 27; stall_pct = 27; end
			endcase
			md = MIN_DIST_W'($urandom_range(16'hffff));
			fb = FB_W'($urandom & ((32'h1 << $urandom_range(24, 1)) - 1));
			case (k)
				0: begin md = MIN_DIST_RST; fb = FB_RST; end
				2: md = 16'hffff;
				4: fb = 24'hffffff;
				default: ;
			endcase
			set_geometry(md, fb);
			sent = 0;
			while (sent < 100) begin
				case ($urandom_range(19))
					0: len = 1;
					1, 2, 3: len = $urandom_range(60, 13);
					default: len = $urandom_range(12, 1);
				endcase
				for (i = 0; i < len; i++)
					send_pixel(random_disparity(), i == len - 1);
				sent += len;
				if ($urandom_range(29) == 0)
					hold_until_empty();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_default_geometry();
		test_register_extremes();
		test_long_frame();
		test_random_frames();
		finish_outstanding();
		if (mismatches == 0 && pending_stats.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
